// ===== sv/greedy_priority_job_scheduler_defines.svh =====
// Assertion macros shared by the scheduler's checker.
`ifndef GREEDY_PRIORITY_JOB_SCHEDULER_DEFINES_SVH
`define GREEDY_PRIORITY_JOB_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPJS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPJS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gpjs_pkg.sv =====
// Shared constants, codes and types of the greedy priority job scheduler.
package gpjs_pkg;

  localparam int DEF_MAX_JOBS    = 256;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_UNIT_BITS   = 16;
  localparam int COST_BITS       = 48;

  localparam logic [1:0] REQ_ARRIVE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Flags of the search token that walks the cell chain.
  typedef struct packed {
    logic active;
    logic best_found;
    logic free_found;
  } probe_t;

  // Update broadcast to all cells at the end of an item.
  typedef struct packed {
    logic load;
    logic dec;
    logic clr;
  } cmd_t;

endpackage

// ===== sv/gpjs_if.sv =====
// Request and result channel interfaces of the scheduler.
interface gpjs_in_if #(
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS,
  parameter int UNIT_BITS   = gpjs_pkg::DEF_UNIT_BITS
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [WEIGHT_BITS-1:0] job_weight;
  logic [UNIT_BITS-1:0]   job_units;

  modport source (output valid, output req_type, output job_weight, output job_units,
                  input ready);
  modport sink (input valid, input req_type, input job_weight, input job_units,
                output ready);
endinterface

interface gpjs_out_if #(
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           served;
  logic [WEIGHT_BITS-1:0]         served_weight;
  logic [gpjs_pkg::COST_BITS-1:0] outstanding_cost;
  logic                           table_full;

  modport source (output valid, output served, output served_weight,
                  output outstanding_cost, output table_full, input ready);
  modport sink (input valid, input served, input served_weight,
                input outstanding_cost, input table_full, output ready);
endinterface

// ===== sv/greedy_priority_job_scheduler.sv =====
// Top level of the greedy priority job scheduler: sequencer plus a chain of job cells.
//
// The scheduler keeps up to MAX_JOBS pending jobs, one per cell of a linear
// chain, and answers every request beat with exactly one result beat. An
// arrive or a tick launches a search token at cell 0 that moves one cell per
// clock, picking up the heaviest job (the lowest slot on equal weights) and
// the lowest free slot as it passes; when it leaves the last cell the
// sequencer broadcasts one update to the chain and registers the result. Such
// a request holds off the next accepted beat until the token has walked the
// whole cell chain. A clear, an arrive with zero units and the unused request
// code skip the walk and go straight to the update. The result sits in an
// output register, so a new request is taken while the previous result still
// waits; it is then held back only at the very end, until that result is
// taken. The outstanding cost is a 48-bit running total that wraps, and the
// weight times units product of an arrive is formed by a single registered
// multiplier at the accept edge.
module greedy_priority_job_scheduler #(
  parameter int MAX_JOBS    = gpjs_pkg::DEF_MAX_JOBS,
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS,
  parameter int UNIT_BITS   = gpjs_pkg::DEF_UNIT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  gpjs_in_if.sink    in_req,
  gpjs_out_if.source out_res
);

  // Enough bits to name every slot.
  localparam int IDX_W = $clog2(MAX_JOBS);

  // Links between neighbors: entry g feeds cell g, entry MAX_JOBS returns to
  // the sequencer.
  gpjs_pkg::probe_t       probe_w    [MAX_JOBS+1];
  logic [WEIGHT_BITS-1:0] best_w_w   [MAX_JOBS+1];
  logic [IDX_W-1:0]       best_idx_w [MAX_JOBS+1];
  logic [IDX_W-1:0]       free_idx_w [MAX_JOBS+1];

  // The update broadcast reaches every cell in the same cycle.
  gpjs_pkg::cmd_t         cmd;
  logic [IDX_W-1:0]       cmd_idx;
  logic [WEIGHT_BITS-1:0] cmd_weight;
  logic [UNIT_BITS-1:0]   cmd_units;

  gpjs_ctrl #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .UNIT_BITS   (UNIT_BITS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .out_res      (out_res),
    .probe_o      (probe_w[0]),
    .probe_i      (probe_w[MAX_JOBS]),
    .best_w_i     (best_w_w[MAX_JOBS]),
    .best_idx_i   (best_idx_w[MAX_JOBS]),
    .free_idx_i   (free_idx_w[MAX_JOBS]),
    .cmd_o        (cmd),
    .cmd_idx_o    (cmd_idx),
    .cmd_weight_o (cmd_weight),
    .cmd_units_o  (cmd_units)
  );

  // The token enters with nothing found, so its payload starts at zero.
  assign best_w_w[0]   = '0;
  assign best_idx_w[0] = '0;
  assign free_idx_w[0] = '0;

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    gpjs_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .UNIT_BITS   (UNIT_BITS),
      .IDX_W       (IDX_W),
      .CELL_IDX    (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .probe_i      (probe_w[g]),
      .best_w_i     (best_w_w[g]),
      .best_idx_i   (best_idx_w[g]),
      .free_idx_i   (free_idx_w[g]),
      .probe_o      (probe_w[g+1]),
      .best_w_o     (best_w_w[g+1]),
      .best_idx_o   (best_idx_w[g+1]),
      .free_idx_o   (free_idx_w[g+1]),
      .cmd_i        (cmd),
      .cmd_idx_i    (cmd_idx),
      .cmd_weight_i (cmd_weight),
      .cmd_units_i  (cmd_units)
    );
  end

endmodule

// ===== sv/gpjs_cell.sv =====
// One job slot of the scheduler chain: holds a job and relays the search token.
module gpjs_cell #(
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS,
  parameter int UNIT_BITS   = gpjs_pkg::DEF_UNIT_BITS,
  parameter int IDX_W       = 8,
  parameter int CELL_IDX    = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gpjs_pkg::probe_t       probe_i,
  input  logic [WEIGHT_BITS-1:0] best_w_i,
  input  logic [IDX_W-1:0]       best_idx_i,
  input  logic [IDX_W-1:0]       free_idx_i,
  output gpjs_pkg::probe_t       probe_o,
  output logic [WEIGHT_BITS-1:0] best_w_o,
  output logic [IDX_W-1:0]       best_idx_o,
  output logic [IDX_W-1:0]       free_idx_o,
  input  gpjs_pkg::cmd_t         cmd_i,
  input  logic [IDX_W-1:0]       cmd_idx_i,
  input  logic [WEIGHT_BITS-1:0] cmd_weight_i,
  input  logic [UNIT_BITS-1:0]   cmd_units_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                   valid_r;
  logic [WEIGHT_BITS-1:0] weight_r;
  logic [UNIT_BITS-1:0]   units_r;

  gpjs_pkg::probe_t       probe_r, probe_nxt;
  logic [WEIGHT_BITS-1:0] best_w_r, best_w_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;

  logic take_best;
  logic take_free;
  logic hit;

  // A strictly larger weight wins, so the lowest slot keeps a tie.
  assign take_best = valid_r && (!probe_i.best_found || (weight_r > best_w_i));
  assign take_free = !valid_r && !probe_i.free_found;
  assign hit       = (cmd_idx_i == MY_IDX);

  always_comb begin
    probe_nxt            = probe_i;
    probe_nxt.best_found = probe_i.best_found | valid_r;
    probe_nxt.free_found = probe_i.free_found | !valid_r;
    best_w_nxt           = take_best ? weight_r : best_w_i;
    best_idx_nxt         = take_best ? MY_IDX : best_idx_i;
    free_idx_nxt         = take_free ? MY_IDX : free_idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_w_r   <= best_w_nxt;
    best_idx_r <= best_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd_i.clr) begin
      valid_r <= 1'b0;
    end else if (cmd_i.load && hit) begin
      valid_r <= 1'b1;
    end else if (cmd_i.dec && hit && (units_r == UNIT_BITS'(1))) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load && hit) begin
      weight_r <= cmd_weight_i;
      units_r  <= cmd_units_i;
    end else if (cmd_i.dec && hit) begin
      units_r  <= units_r - UNIT_BITS'(1);
    end
  end

  assign probe_o    = probe_r;
  assign best_w_o   = best_w_r;
  assign best_idx_o = best_idx_r;
  assign free_idx_o = free_idx_r;

endmodule

// ===== sv/gpjs_ctrl.sv =====
// Sequencer of the scheduler: handshakes, search launch, cost and result register.
module gpjs_ctrl #(
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS,
  parameter int UNIT_BITS   = gpjs_pkg::DEF_UNIT_BITS,
  parameter int IDX_W       = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  gpjs_in_if.sink                in_req,
  gpjs_out_if.source             out_res,
  output gpjs_pkg::probe_t       probe_o,
  input  gpjs_pkg::probe_t       probe_i,
  input  logic [WEIGHT_BITS-1:0] best_w_i,
  input  logic [IDX_W-1:0]       best_idx_i,
  input  logic [IDX_W-1:0]       free_idx_i,
  output gpjs_pkg::cmd_t         cmd_o,
  output logic [IDX_W-1:0]       cmd_idx_o,
  output logic [WEIGHT_BITS-1:0] cmd_weight_o,
  output logic [UNIT_BITS-1:0]   cmd_units_o
);

  localparam int PROD_BITS = WEIGHT_BITS + UNIT_BITS;
  localparam int CB        = gpjs_pkg::COST_BITS;

  gpjs_pkg::state_t state_r, state_nxt;

  logic                   accept;
  logic                   needs_sweep;
  logic                   latch_probe;
  logic                   finish;
  logic                   out_free;

  logic                   start_r;
  logic [1:0]             req_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [UNIT_BITS-1:0]   u_r;
  logic                   u_nz_r;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;

  logic                   bf_r, ff_r;
  logic [WEIGHT_BITS-1:0] bw_r;
  logic [IDX_W-1:0]       bi_r, fi_r;

  logic [CB-1:0]          cost_r, cost_nxt;
  gpjs_pkg::cmd_t         cmd;
  logic [IDX_W-1:0]       cmd_idx;
  logic                   res_served, res_full;

  logic                   out_valid_r;
  logic                   out_served_r;
  logic [WEIGHT_BITS-1:0] out_sw_r;
  logic                   out_full_r;

  assign accept      = in_req.valid && in_req.ready;
  assign needs_sweep = (in_req.req_type == gpjs_pkg::REQ_TICK) ||
                       ((in_req.req_type == gpjs_pkg::REQ_ARRIVE) &&
                        (in_req.job_units != '0));
  assign out_free    = !out_valid_r || out_res.ready;
  assign prod_nxt    = PROD_BITS'(in_req.job_weight) * PROD_BITS'(in_req.job_units);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gpjs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = needs_sweep ? gpjs_pkg::ST_SWEEP : gpjs_pkg::ST_DONE;
        end
      end
      gpjs_pkg::ST_SWEEP: begin
        if (probe_i.active) begin
          state_nxt = gpjs_pkg::ST_DONE;
        end
      end
      gpjs_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gpjs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpjs_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_req.ready = 1'b0;
    latch_probe  = 1'b0;
    finish       = 1'b0;
    case (state_r)
      gpjs_pkg::ST_IDLE:  in_req.ready = 1'b1;
      gpjs_pkg::ST_SWEEP: latch_probe  = probe_i.active;
      gpjs_pkg::ST_DONE:  finish       = out_free;
      default: ;
    endcase
  end

  // Outcome of the held item from the latched search result.
  always_comb begin
    cmd        = '0;
    cmd_idx    = fi_r;
    cost_nxt   = cost_r;
    res_served = 1'b0;
    res_full   = 1'b0;
    case (req_r)
      gpjs_pkg::REQ_ARRIVE: begin
        if (u_nz_r) begin
          if (!ff_r) begin
            res_full = 1'b1;
          end else begin
            cmd.load = 1'b1;
            cmd_idx  = fi_r;
            cost_nxt = cost_r + CB'(prod_r);
          end
        end
      end
      gpjs_pkg::REQ_TICK: begin
        if (bf_r) begin
          res_served = 1'b1;
          cmd.dec    = 1'b1;
          cmd_idx    = bi_r;
          cost_nxt   = cost_r - CB'(bw_r);
        end
      end
      gpjs_pkg::REQ_CLEAR: begin
        cmd.clr  = 1'b1;
        cost_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpjs_pkg::ST_IDLE;
      start_r     <= 1'b0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept && needs_sweep;
      if (finish) begin
        cost_r      <= cost_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req.req_type;
      w_r    <= in_req.job_weight;
      u_r    <= in_req.job_units;
      u_nz_r <= (in_req.job_units != '0);
      prod_r <= prod_nxt;
    end
    if (latch_probe) begin
      bf_r <= probe_i.best_found;
      ff_r <= probe_i.free_found;
      bw_r <= best_w_i;
      bi_r <= best_idx_i;
      fi_r <= free_idx_i;
    end
    if (finish) begin
      out_served_r <= res_served;
      out_sw_r     <= res_served ? bw_r : '0;
      out_full_r   <= res_full;
    end
  end

  always_comb begin
    probe_o            = '0;
    probe_o.active     = start_r;
  end

  assign cmd_o        = finish ? cmd : '0;
  assign cmd_idx_o    = cmd_idx;
  assign cmd_weight_o = w_r;
  assign cmd_units_o  = u_r;

  assign out_res.valid            = out_valid_r;
  assign out_res.served           = out_served_r;
  assign out_res.served_weight    = out_sw_r;
  assign out_res.outstanding_cost = cost_r;
  assign out_res.table_full       = out_full_r;

endmodule

// ===== sv/gpjs_checker.sv =====
// Port-level assertion checker of the scheduler and its bind to the top level.
`include "greedy_priority_job_scheduler_defines.svh"

module gpjs_checker #(
  parameter int WEIGHT_BITS = gpjs_pkg::DEF_WEIGHT_BITS
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_served,
  input logic [WEIGHT_BITS-1:0]         out_served_weight,
  input logic [gpjs_pkg::COST_BITS-1:0] out_cost,
  input logic                           out_table_full
);

  `GPJS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `GPJS_ASSERT_NOW(a_idle_weight_zero, out_valid && !out_served, out_served_weight == '0, "weight without service")
  `GPJS_ASSERT_NOW(a_served_not_full, out_valid && out_served, !out_table_full, "served and full together")
  `GPJS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_served) && $stable(out_served_weight) && $stable(out_cost) && $stable(out_table_full), "stalled result changed")

endmodule

bind greedy_priority_job_scheduler gpjs_checker #(
  .WEIGHT_BITS (WEIGHT_BITS)
) u_gpjs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_served        (out_res.served),
  .out_served_weight (out_res.served_weight),
  .out_cost          (out_res.outstanding_cost),
  .out_table_full    (out_res.table_full)
);
